@@ rtl/core/gtd_pkg.sv @@
package gtd_pkg;

  // Shared multiplier: signed operands and registered product.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // Resonator and power formats.
  localparam int COEFF_W    = 17;
  localparam int LEN_W      = 11;
  localparam int STATE_W    = 24;
  localparam int POWER_W    = 48;
  localparam int ACC_W      = 66;
  localparam int COEFF_FRAC = 14;

  localparam logic signed [STATE_W-1:0] STATE_MAX = 24'sh7FFFFF;
  localparam logic signed [STATE_W-1:0] STATE_MIN = 24'sh800000;
  localparam logic [POWER_W-1:0]        POWER_MAX = '1;

  // Configuration register indexes and reset values.
  typedef enum logic [0:0] {
    REG_COEFF = 1'b0,
    REG_LEN   = 1'b1
  } reg_idx_t;

  localparam logic signed [COEFF_W-1:0] COEFF_RESET = 17'sd23180;
  localparam logic [LEN_W-1:0]          LEN_RESET   = 11'd255;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MQ,
    ST_UPD,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6,
    ST_P7,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/gtd_mul.sv @@
module gtd_mul
  import gtd_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  // One signed multiply per cycle, product registered.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/core/goertzel_tone_detector_top.sv @@
// Single-bin Goertzel tone detector. Each input word carries one unsigned ADC
// sample, which is fed through a second-order resonator whose coefficient is
// the Q3.14 register two_cos_coefficient; the resonator state saturates to
// 24-bit signed. After block_length samples (0 acts as 1, values above
// MAX_BLOCK act as MAX_BLOCK) one output word carries the 48-bit clamped bin
// power, and tuser flags any clamp in that block. All multiplies run on one
// shared 25x25 registered multiplier under a small sequencer: an ordinary
// sample occupies the block through its accept, multiply and update states,
// and the last sample of a block then runs the five power products and the
// final sum, plus any time spent waiting for the previous output word to be
// taken. There is no start-up sweep; the block is ready right after reset.
module goertzel_tone_detector_top
  import gtd_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_BLOCK   = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Configuration write port.
  input  logic                                     cfg_we,
  input  logic [0:0]                               cfg_index,
  input  logic [COEFF_W-1:0]                       cfg_data,
  // Input stream.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
  // Output stream.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [POWER_W-1:0]                       m_axis_tdata,  // bin_power
  output logic                                     m_axis_tuser   // saturated
);

  localparam int CNTW = $clog2(MAX_BLOCK);
  localparam int CW   = $clog2(MAX_BLOCK + 1);
  localparam int QW   = 40;

  state_t state;
  state_t state_next;

  logic signed [COEFF_W-1:0] coeff;
  logic [LEN_W-1:0]          block_length;
  logic [SAMPLE_BITS-1:0]    sample_reg;
  logic signed [STATE_W-1:0] d1;
  logic signed [STATE_W-1:0] d2;
  logic [CNTW-1:0]           count;
  logic                      clamp_seen;
  logic signed [STATE_W-1:0] mhi;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   xprod;

  logic                      out_valid;
  logic [POWER_W-1:0]        out_power;
  logic                      out_sat;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [CW-1:0]             len_eff;
  logic [CW-1:0]             count_inc;
  logic                      block_end;
  logic signed [QW-1:0]      q0_wide;
  logic signed [STATE_W-1:0] q0_sat;
  logic                      q0_clamp;
  logic [POWER_W-1:0]        power_final;
  logic                      sat_final;
  logic                      out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff        <= COEFF_RESET;
      block_length <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF: coeff        <= $signed(cfg_data);
        REG_LEN:   block_length <= cfg_data[LEN_W-1:0];
        default:   ;
      endcase
    end
  end

  // Effective block length, limited to one through MAX_BLOCK.
  always_comb begin
    if (block_length == '0) begin
      len_eff = CW'(1);
    end else if (32'(block_length) > 32'(MAX_BLOCK)) begin
      len_eff = CW'(MAX_BLOCK);
    end else begin
      len_eff = CW'(block_length);
    end
  end

  assign count_inc = CW'(count) + CW'(1);
  assign block_end = (count_inc >= len_eff);

  // Resonator update from the registered coefficient product.
  always_comb begin
    q0_wide = QW'(prod >>> COEFF_FRAC) - QW'(d2)
            + QW'($signed({1'b0, sample_reg}));
    if (q0_wide > QW'(STATE_MAX)) begin
      q0_sat   = STATE_MAX;
      q0_clamp = 1'b1;
    end else if (q0_wide < QW'(STATE_MIN)) begin
      q0_sat   = STATE_MIN;
      q0_clamp = 1'b1;
    end else begin
      q0_sat   = q0_wide[STATE_W-1:0];
      q0_clamp = 1'b0;
    end
  end

  // Power clamp to the 48-bit unsigned range.
  always_comb begin
    if (acc[ACC_W-1]) begin
      power_final = '0;
      sat_final   = 1'b1;
    end else if (|acc[ACC_W-2:POWER_W]) begin
      power_final = POWER_MAX;
      sat_final   = 1'b1;
    end else begin
      power_final = acc[POWER_W-1:0];
      sat_final   = clamp_seen;
    end
  end

  assign out_free = !out_valid || m_axis_tready;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      ST_P1: begin
        mul_a = MUL_W'(d1);
        mul_b = MUL_W'(d1);
      end
      ST_P2: begin
        mul_a = MUL_W'(d2);
        mul_b = MUL_W'(d2);
      end
      ST_P3: begin
        mul_a = MUL_W'(d1);
        mul_b = MUL_W'(d2);
      end
      ST_P4: begin
        // Low half of d1*d2 as an unsigned partial operand.
        mul_a = $signed({1'b0, prod[STATE_W-1:0]});
        mul_b = MUL_W'(coeff);
      end
      ST_P5: begin
        mul_a = MUL_W'(mhi);
        mul_b = MUL_W'(coeff);
      end
      default: begin
        mul_a = MUL_W'(coeff);
        mul_b = MUL_W'(d1);
      end
    endcase
  end

  gtd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_MQ;
        end
      end
      ST_MQ:  state_next = ST_UPD;
      ST_UPD: state_next = block_end ? ST_P1 : ST_IDLE;
      ST_P1:  state_next = ST_P2;
      ST_P2:  state_next = ST_P3;
      ST_P3:  state_next = ST_P4;
      ST_P4:  state_next = ST_P5;
      ST_P5:  state_next = ST_P6;
      ST_P6:  state_next = ST_P7;
      ST_P7:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sample capture and power datapath (no reset needed).
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
      ST_P2:   acc   <= ACC_W'(prod);
      ST_P3:   acc   <= acc + ACC_W'(prod);
      ST_P4:   mhi   <= prod[2*STATE_W-1:STATE_W];
      ST_P5:   xprod <= ACC_W'(prod);
      ST_P6:   xprod <= xprod + (ACC_W'(prod) <<< STATE_W);
      ST_P7:   acc   <= acc - (xprod >>> COEFF_FRAC);
      default: ;
    endcase
  end

  // Resonator state and block counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      d1         <= '0;
      d2         <= '0;
      count      <= '0;
      clamp_seen <= 1'b0;
    end else begin
      case (state)
        ST_UPD: begin
          d2         <= d1;
          d1         <= q0_sat;
          clamp_seen <= clamp_seen | q0_clamp;
          if (!block_end) begin
            count <= count_inc[CNTW-1:0];
          end
        end
        ST_DONE: begin
          if (out_free) begin
            d1         <= '0;
            d2         <= '0;
            count      <= '0;
            clamp_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_power <= power_final;
      out_sat   <= sat_final;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_power;
  assign m_axis_tuser  = out_sat;

  // A fresh block starts from a cleared resonator.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && count == '0) |-> (d1 == '0 && d2 == '0))
    else $error("resonator not cleared at block start");

  // An output word appears only when the sequencer finishes a block.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_DONE)
    else $error("output word without finished block");

  // Finishing a block with room for the word returns to idle cleared.
  a_done_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (state == ST_IDLE && count == '0 && m_axis_tvalid))
    else $error("block finish did not complete");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import gtd_pkg::*;

  localparam int SAMPLE_W   = 12;
  localparam int DATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int BLOCK_CAP  = 1024;
  localparam int IDLE_WAIT  = 16;
  localparam int DRAIN_WAIT = 32;
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 2000;
  localparam int MAX_SHOWN  = 10;
  localparam int NUM_ITEMS  = 1950;

  // Waveform families used to fill sample words.
  typedef enum int {
    SHP_NOISE,
    SHP_FULL_SCALE,
    SHP_SQUARE,
    SHP_CORNERS,
    SHP_IMPULSE
  } shape_t;

  // One expected output word.
  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               clamped;
  } power_word_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic [0:0]         cfg_index     = REG_COEFF;
  logic [COEFF_W-1:0] cfg_data      = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata  = '0;   // sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [POWER_W-1:0] m_axis_tdata;         // bin_power
  logic               m_axis_tuser;         // saturated

  // Traffic shaping shared by the driver and the receiver.
  logic        calm      = 1'b0;
  int unsigned stall_req = 0;
  int unsigned stall_ack = 0;
  int          hold_left = 0;
  bit          pressed   = 1'b0;

  logic [SAMPLE_W-1:0] sample_queue[$];
  power_word_t         power_expect[$];
  int                  issued       = 0;
  int                  mismatch_cnt = 0;
  int                  quiet_cycles = 0;

  // Predictor copy of the resonator, its block counters and its registers.
  longint res_d1      = 0;
  longint res_d2      = 0;
  int     blk_count   = 0;
  bit     blk_clamp   = 1'b0;
  longint coef_q14    = longint'(COEFF_RESET);
  int     blk_len_reg = int'(LEN_RESET);

  goertzel_tone_detector_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Track a register write in the predictor.
  function automatic void apply_reg(input logic [0:0] idx, input logic [COEFF_W-1:0] val);
    case (reg_idx_t'(idx))
      REG_COEFF: begin
        coef_q14 = longint'(signed'(val));
      end
      REG_LEN: begin
        blk_len_reg = int'(val[LEN_W-1:0]);
      end
      default: begin
      end
    endcase
  endfunction

  // Advance the resonator by one sample and queue the bin power at block end.
  function automatic void resonate_sample(input logic [SAMPLE_W-1:0] smp);
    longint      q0;
    longint      pwr;
    int          eff_len;
    power_word_t w;
    q0 = ((coef_q14 * res_d1) >>> COEFF_FRAC) - res_d2 + longint'(smp);
    if (q0 > longint'(STATE_MAX)) begin
      q0 = longint'(STATE_MAX);
      blk_clamp = 1'b1;
    end else if (q0 < longint'(STATE_MIN)) begin
      q0 = longint'(STATE_MIN);
      blk_clamp = 1'b1;
    end
    res_d2 = res_d1;
    res_d1 = q0;

    eff_len = (blk_len_reg < 1) ? 1 : (blk_len_reg > BLOCK_CAP) ? BLOCK_CAP : blk_len_reg;
    blk_count++;
    if (blk_count < eff_len) begin
      return;
    end

    pwr = res_d1 * res_d1 + res_d2 * res_d2 - ((res_d1 * res_d2 * coef_q14) >>> COEFF_FRAC);
    w.clamped = blk_clamp;
    if (pwr < 0) begin
      pwr = 0;
      w.clamped = 1'b1;
    end else if (pwr > longint'(POWER_MAX)) begin
      pwr = longint'(POWER_MAX);
      w.clamped = 1'b1;
    end
    w.power = pwr[POWER_W-1:0];
    power_expect.push_back(w);

    res_d1    = 0;
    res_d2    = 0;
    blk_count = 0;
    blk_clamp = 1'b0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] make_sample(input shape_t shape, input int n);
    case (shape)
      SHP_FULL_SCALE: return '1;
      SHP_SQUARE:     return ((n / 4) % 2 == 0) ? '1 : '0;
      SHP_IMPULSE:    return (n == 0) ? SAMPLE_W'(1) : '0;
      SHP_CORNERS: begin
        case (n % 4)
          0:       return '0;
          1:       return '1;
          2:       return SAMPLE_W'(12'hAAA);
          default: return SAMPLE_W'(12'h555);
        endcase
      end
      default:        return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Wait until every sample is taken and every power word has come back.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_axis_tvalid || power_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Both registers are written back to back, holding the write enable high.
  task automatic write_regs(input int coeff, input int blen);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COEFF;
    cfg_data  <= COEFF_W'(coeff);
    @(posedge clk);
    cfg_index <= REG_LEN;
    cfg_data  <= COEFF_W'(blen);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int coeff, input int blen, input int n, input shape_t shape);
    wait_idle();
    write_regs(coeff, blen);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      sample_queue.push_back(make_sample(shape, i));
    end
    issued += n;
  endtask

  // Random settings; most phases feed whole blocks, some leave a block half done.
  task automatic random_phases(input int upto);
    int     pick;
    int     coeff;
    int     blen;
    int     eff;
    int     n;
    shape_t shape;
    while (issued < upto) begin
      calm <= (issued >= 500 && issued < 800);

      pick = $urandom_range(99);
      if (pick < 65) begin
        coeff = int'($urandom_range(65536)) - 32768;
      end else if (pick < 85) begin
        case ($urandom_range(6))
          0:       coeff = -65536;
          1:       coeff = 65535;
          2:       coeff = -32768;
          3:       coeff = 32768;
          4:       coeff = 0;
          5:       coeff = 16384;
          default: coeff = -16384;
        endcase
      end else begin
        coeff = int'($urandom_range(131071)) - 65536;
      end

      // One short-block phase runs against a long receiver hold-off.
      if (!pressed && issued >= 300) begin
        pressed = 1'b1;
        stall_req <= stall_req + 1;
        run_phase(coeff, 1, 60, SHP_NOISE);
        continue;
      end

      pick = $urandom_range(99);
      if (pick < 55) begin
        blen = $urandom_range(12, 1);
      end else if (pick < 80) begin
        blen = $urandom_range(64, 13);
      end else if (pick < 92) begin
        blen = $urandom_range(1);
      end else begin
        blen = $urandom_range(200, 65);
      end
      eff = (blen == 0) ? 1 : blen;

      if ($urandom_range(99) < 75) begin
        n = (eff > 64) ? eff : eff * $urandom_range(4, 1);
      end else begin
        n = $urandom_range(2 * eff, 1);
      end

      if ($urandom_range(99) < 55) begin
        shape = SHP_NOISE;
      end else begin
        shape = shape_t'($urandom_range(3));
      end
      run_phase(coeff, blen, n, shape);
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero length acts as one: every corner sample gives its own word.
    run_phase(0, 0, 4, SHP_CORNERS);
    // Coefficient near four with an impulse: the power goes negative and clamps.
    run_phase(65535, 3, 3, SHP_IMPULSE);
    run_phase(-32768, 2, 2, SHP_FULL_SCALE);
    run_phase(int'(COEFF_RESET), 16, 16, SHP_SQUARE);

    random_phases(700);
    calm <= 1'b0;

    // Length beyond the cap acts as the cap; a DC input with the coefficient at 2.0 saturates.
    run_phase(32768, 2047, BLOCK_CAP, SHP_FULL_SCALE);
    // Partial block at the cap; the next phase shortens the length mid-block.
    run_phase(int'($urandom_range(65536)) - 32768, BLOCK_CAP, 40, SHP_NOISE);

    random_phases(NUM_ITEMS);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (power_expect.size() != 0) begin
      flag_error($sformatf("%0d power words never arrived", power_expect.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sample driver: the next word goes out once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(sample_queue.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (stall_ack != stall_req) begin
      stall_ack     <= stall_req;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Monitor: feed the predictor and check each output word against the oldest expectation.
  always @(posedge clk) begin : check_outputs
    power_word_t want;
    if (!rst) begin
      if (cfg_we) begin
        apply_reg(cfg_index, cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        resonate_sample(s_axis_tdata[SAMPLE_W-1:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (power_expect.size() == 0) begin
          flag_error($sformatf("unexpected output word: bin_power %0d saturated %0b",
                               m_axis_tdata, m_axis_tuser));
        end else begin
          want = power_expect.pop_front();
          if (m_axis_tdata !== want.power) begin
            flag_error($sformatf("bin_power expected %0d, got %0d", want.power, m_axis_tdata));
          end
          if (m_axis_tuser !== want.clamped) begin
            flag_error($sformatf("saturated expected %0b, got %0b", want.clamped, m_axis_tuser));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
rtl/core/gtd_pkg.sv
rtl/core/gtd_mul.sv
rtl/core/goertzel_tone_detector_top.sv
tb/tb_top.sv
